// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL of the stencil block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/j7s_pkg.sv =====
// Shared constants and types of the 3-D Jacobi 7-point stencil block.
package j7s_pkg;

   localparam int MAX_EDGE    = 64;
   localparam int RESET_EDGE  = 8;
   localparam int CSR_W       = 7;
   localparam int DATA_W      = 32;

   // window geometry
   localparam int WIN_LINE    = MAX_EDGE + 2;
   localparam int LINE_W      = $clog2(WIN_LINE + 2);   // holds line + 1
   localparam int LINE_DEPTH  = 2 ** LINE_W;
   localparam int PLANE_W     = $clog2(WIN_LINE * WIN_LINE + WIN_LINE + 1);
   localparam int PLANE_DEPTH = 2 ** PLANE_W;

   // arithmetic widths
   localparam int PSUM_W      = DATA_W + 2;   // sum of three words
   localparam int SUM_W       = DATA_W + 3;   // sum of six words
   localparam int HALF_W      = DATA_W + 1;   // |sum| / 2 < 2^33
   localparam int RECIP_W     = 34;
   localparam int RECIP_SHIFT = 35;
   localparam int LO_W        = 16;
   localparam int HI_W        = HALF_W - LO_W;
   localparam int PLO_W       = LO_W + RECIP_W;
   localparam int PHI_W       = HI_W + RECIP_W;
   localparam int FULL_W      = PHI_W + LO_W;
   localparam int RES_W       = DATA_W + 2;

   // (2^35 + 1) / 3: exact floor(h / 3) for h < 2^33
   localparam logic [RECIP_W-1:0] RECIP3 = 34'd11453246123;

   localparam logic signed [RES_W-1:0] ONE_Q16 = 34'sd65536;
   localparam logic signed [RES_W-1:0] SAT_HI  = {3'b000, {(DATA_W-1){1'b1}}};
   localparam logic signed [RES_W-1:0] SAT_LO  = {3'b111, {(DATA_W-1){1'b0}}};

   typedef logic signed [DATA_W-1:0] word_type;

   typedef struct packed {
      logic [LINE_W-1:0]  line;
      logic [PLANE_W-1:0] plane;
   } geom_type;

   typedef struct packed {
      logic valid;
      logic emit;
      logic last;
   } beat_type;

   typedef struct packed {
      logic valid;
      logic last;
   } ctl_type;

   // six face neighbours of the voxel being finished
   typedef struct packed {
      word_type cur;     // z + 1
      word_type near;    // y + 1
      word_type far;     // y - 1
      word_type back;    // z - 1
      word_type xhi;     // x + 1
      word_type xlo;     // x - 1
   } taps_type;

   typedef struct packed {
      logic     valid;
      logic     last;
      word_type value;
   } res_type;

endpackage

// ===== design/jacobi_7point_stencil_3d.sv =====
// Top level of the 3-D Jacobi 7-point stencil block.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------------
//  req     | in  | req_tvalid/req_tready| tdata[31:0] voxel_value, tuser first_of_grid
//  rsp     | out | rsp_tvalid/rsp_tready| tdata[31:0] updated_value, tlast last_of_grid
//  csr     | in  | csr_wr_en            | csr_wr_data[6:0] grid_edge
//
//  One voxel beat per cycle while the pipeline does not stall; the plane RAM
//  and the line RAM each serve two reads and one write per beat, which sets
//  that figure. Once the beat of its z + 1 neighbour is taken, a result passes
//  s1, c2 to c6 and the output register; x/y halo beats and planes z = 0, 1 give no result.
//  Reset is synchronous; no clearing pass, the window fills with the stream.
//  The pipeline only stalls when the output register holds an untaken
//  result and a result is ready behind it; bubbles are squeezed out.
`include "assert_macros.svh"

module jacobi_7point_stencil_3d (
   input  logic                        clock,
   input  logic                        reset,
   // slave side
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [j7s_pkg::DATA_W-1:0]  req_tdata,   // [31:0] voxel_value
   input  logic                        req_tuser,   // [0] first_of_grid
   // master side
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [j7s_pkg::DATA_W-1:0]  rsp_tdata,   // [31:0] updated_value
   output logic                        rsp_tlast,   // last_of_grid
   // configuration
   input  logic                        csr_wr_en,
   input  logic [j7s_pkg::CSR_W-1:0]   csr_wr_data  // grid_edge
);
   import j7s_pkg::*;

   // effective edge n and derived geometry
   logic [LINE_W-1:0]  edge_ff, edge_in;
   geom_type           geom_ff, geom_in;

   // position of the next voxel
   logic [LINE_W-1:0]  pos_x_ff, pos_x_in;
   logic [LINE_W-1:0]  pos_y_ff, pos_y_in;
   logic [LINE_W-1:0]  pos_z_ff, pos_z_in;
   logic [LINE_W-1:0]  px, py, pz;
   logic [LINE_W-1:0]  n_plus1;

   logic               accept;
   logic               move;
   logic               s0_emit, s0_last;

   beat_type           s1_beat;
   taps_type           taps;
   res_type            res;

   // output register
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic               rsp_tlast_ff, rsp_tlast_in;
   word_type           rsp_tdata_ff, rsp_tdata_in;
   logic               out_load;

   // Hold everything only when a result would run into a stalled output.
   assign move       = !(rsp_tvalid_ff && !rsp_tready && res.valid);
   assign req_tready = move;
   assign accept     = req_tvalid && move;

   // config: grid_edge of zero acts as one, above the limit as the limit
   always_comb begin
      edge_in = edge_ff;
      geom_in = geom_ff;
      if (csr_wr_en) begin
         if (csr_wr_data == '0) begin
            edge_in = LINE_W'(1);
         end else if (int'(csr_wr_data) > MAX_EDGE) begin
            edge_in = LINE_W'(MAX_EDGE);
         end else begin
            edge_in = LINE_W'(csr_wr_data);
         end
         geom_in.line  = edge_in + LINE_W'(2);
         geom_in.plane = PLANE_W'(geom_in.line) * PLANE_W'(geom_in.line);
      end
   end

   // position of this beat; first_of_grid restarts at the origin
   always_comb begin
      px      = req_tuser ? '0 : pos_x_ff;
      py      = req_tuser ? '0 : pos_y_ff;
      pz      = req_tuser ? '0 : pos_z_ff;
      n_plus1 = edge_ff + LINE_W'(1);
      // a voxel is finished when its z + 1 neighbour arrives
      s0_emit = (pz >= LINE_W'(2)) && (pz <= n_plus1) &&
                (py >= LINE_W'(1)) && (py <= edge_ff) &&
                (px >= LINE_W'(1)) && (px <= edge_ff);
      s0_last = (px == edge_ff) && (py == edge_ff) && (pz == n_plus1);

      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      pos_z_in = pos_z_ff;
      if (csr_wr_en) begin
         pos_x_in = '0;
         pos_y_in = '0;
         pos_z_in = '0;
      end else if (accept) begin
         pos_x_in = px + LINE_W'(1);
         pos_y_in = py;
         pos_z_in = pz;
         if (pos_x_in >= geom_ff.line) begin
            pos_x_in = '0;
            pos_y_in = py + LINE_W'(1);
            if (pos_y_in >= geom_ff.line) begin
               pos_y_in = '0;
               pos_z_in = pz + LINE_W'(1);
               // overrun wraps without a first mark
               if (pos_z_in >= geom_ff.line) begin
                  pos_z_in = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_ff       <= LINE_W'(RESET_EDGE);
         geom_ff.line  <= LINE_W'(RESET_EDGE + 2);
         geom_ff.plane <= PLANE_W'((RESET_EDGE + 2) * (RESET_EDGE + 2));
         pos_x_ff      <= '0;
         pos_y_ff      <= '0;
         pos_z_ff      <= '0;
      end else begin
         edge_ff  <= edge_in;
         geom_ff  <= geom_in;
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         pos_z_ff <= pos_z_in;
      end
   end

   j7s_window u_window (
      .clock   (clock),
      .reset   (reset),
      .move    (move),
      .accept  (accept),
      .cur     (req_tdata),
      .emit    (s0_emit),
      .last    (s0_last),
      .geom    (geom_ff),
      .s1_beat (s1_beat),
      .taps    (taps)
   );

   j7s_mean u_mean (
      .clock   (clock),
      .reset   (reset),
      .move    (move),
      .s1_beat (s1_beat),
      .taps    (taps),
      .res     (res)
   );

   // output register: reload when empty or being taken
   always_comb begin
      out_load      = !rsp_tvalid_ff || rsp_tready;
      rsp_tvalid_in = out_load ? res.valid : rsp_tvalid_ff;
      rsp_tlast_in  = out_load ? res.last  : rsp_tlast_ff;
      rsp_tdata_in  = out_load ? res.value : rsp_tdata_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tlast_ff <= rsp_tlast_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tlast  = rsp_tlast_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // position always stays inside the (n+2)^3 grid
   `ASSERT_IMPLIES(a_pos_in_grid, clock, reset, 1'b1, (pos_x_ff < geom_ff.line) && (pos_y_ff < geom_ff.line) && (pos_z_ff < geom_ff.line), "position left the grid")

   // the beat that finishes the last voxel is followed by the far x halo of that row
   `ASSERT_NEXT(a_last_step, clock, reset, accept && s0_last && !csr_wr_en, pos_x_ff == edge_ff + LINE_W'(1), "bad step after last voxel")

   // an edge write restarts the grid
   `ASSERT_NEXT(a_csr_restart, clock, reset, csr_wr_en, (pos_x_ff == '0) && (pos_y_ff == '0) && (pos_z_ff == '0), "edge write did not restart")

endmodule

// ===== design/j7s_ram.sv =====
// Generic RAM: one write port, two registered read ports.
module j7s_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== design/j7s_window.sv =====
// Plane and line window memories with the first pipeline stage.
module j7s_window (
   input  logic               clock,
   input  logic               reset,
   input  logic               move,
   input  logic               accept,
   input  j7s_pkg::word_type  cur,
   input  logic               emit,
   input  logic               last,
   input  j7s_pkg::geom_type  geom,
   output j7s_pkg::beat_type  s1_beat,
   output j7s_pkg::taps_type  taps
);
   import j7s_pkg::*;

   logic [PLANE_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PLANE_W-1:0]  off_pml, off_ppl;
   logic [LINE_W-1:0]   off_lm1, off_lp1;
   logic [PLANE_W-1:0]  pa_addr, pb_addr;
   logic [LINE_W-1:0]   la_addr, lb_addr;
   logic [2*DATA_W-1:0] pa_data, pb_data;
   logic [DATA_W-1:0]   la_data, lb_data;

   beat_type            s1_ff, s1_in;
   word_type            s1_cur_ff;
   logic [PLANE_W-1:0]  s1_ptr_ff;

   // tap distances in beats
   always_comb begin
      off_pml = geom.plane - PLANE_W'(geom.line);
      off_ppl = geom.plane + PLANE_W'(geom.line);
      off_lm1 = geom.line - LINE_W'(1);
      off_lp1 = geom.line + LINE_W'(1);
      pa_addr = wr_ptr_ff - off_pml;
      pb_addr = wr_ptr_ff - off_ppl;
      la_addr = wr_ptr_ff[LINE_W-1:0] - off_lm1;
      lb_addr = wr_ptr_ff[LINE_W-1:0] - off_lp1;
      wr_ptr_in = accept ? wr_ptr_ff + PLANE_W'(1) : wr_ptr_ff;
      s1_in.valid = accept;
      s1_in.emit  = emit;
      s1_in.last  = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         s1_ff     <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         if (move) begin
            s1_ff <= s1_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         s1_cur_ff <= cur;
         s1_ptr_ff <= wr_ptr_ff;
      end
   end

   // entry t: {voxel t - plane - line, voxel t}
   j7s_ram #(
      .WIDTH (2 * DATA_W),
      .DEPTH (PLANE_DEPTH)
   ) u_plane_ram (
      .clock     (clock),
      .wr_en     (move && s1_ff.valid),
      .wr_addr   (s1_ptr_ff),
      .wr_data   ({pb_data[DATA_W-1:0], s1_cur_ff}),
      .rd_en     (move),
      .rd_addr_a (pa_addr),
      .rd_addr_b (pb_addr),
      .rd_data_a (pa_data),
      .rd_data_b (pb_data)
   );

   // entry t: voxel t - plane + line
   j7s_ram #(
      .WIDTH (DATA_W),
      .DEPTH (LINE_DEPTH)
   ) u_line_ram (
      .clock     (clock),
      .wr_en     (move && s1_ff.valid),
      .wr_addr   (s1_ptr_ff[LINE_W-1:0]),
      .wr_data   (pa_data[DATA_W-1:0]),
      .rd_en     (move),
      .rd_addr_a (la_addr),
      .rd_addr_b (lb_addr),
      .rd_data_a (la_data),
      .rd_data_b (lb_data)
   );

   always_comb begin
      s1_beat   = s1_ff;
      taps.cur  = s1_cur_ff;
      taps.near = pa_data[DATA_W-1:0];
      taps.back = pa_data[2*DATA_W-1:DATA_W];
      taps.far  = pb_data[DATA_W-1:0];
      taps.xhi  = la_data;
      taps.xlo  = lb_data;
   end

endmodule

// ===== design/j7s_mean.sv =====
// Six-neighbour sum, divide by six, add one in Q16.16 and saturate.
module j7s_mean (
   input  logic              clock,
   input  logic              reset,
   input  logic              move,
   input  j7s_pkg::beat_type s1_beat,
   input  j7s_pkg::taps_type taps,
   output j7s_pkg::res_type  res
);
   import j7s_pkg::*;

   ctl_type                   c2_ff, c2_in, c3_ff, c4_ff, c5_ff, c6_ff;
   logic signed [PSUM_W-1:0]  psa_ff, psa_in, psb_ff, psb_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic [SUM_W-1:0]          mag;
   logic                      neg4_ff, neg4_in, neg5_ff, neg6_ff;
   logic [HALF_W-1:0]         half_ff, half_in;
   logic [PLO_W-1:0]          plo_ff, plo_in;
   logic [PHI_W-1:0]          phi_ff, phi_in;
   logic [FULL_W-1:0]         full;
   logic [DATA_W-1:0]         q_ff, q_in;
   logic signed [RES_W-1:0]   rs;
   word_type                  value;

   always_comb begin
      c2_in.valid = s1_beat.valid && s1_beat.emit;
      c2_in.last  = s1_beat.last;
      psa_in = PSUM_W'(taps.cur) + PSUM_W'(taps.near) + PSUM_W'(taps.far);
      psb_in = PSUM_W'(taps.back) + PSUM_W'(taps.xhi) + PSUM_W'(taps.xlo);
      sum_in = SUM_W'(psa_ff) + SUM_W'(psb_ff);
      // truncate toward zero: divide the magnitude, put the sign back after
      neg4_in = sum_ff[SUM_W-1];
      mag     = neg4_in ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      half_in = mag[HALF_W:1];
      plo_in  = PLO_W'(half_ff[LO_W-1:0]) * PLO_W'(RECIP3);
      phi_in  = PHI_W'(half_ff[HALF_W-1:LO_W]) * PHI_W'(RECIP3);
      full    = {phi_ff, LO_W'(0)} + FULL_W'(plo_ff);
      q_in    = full[RECIP_SHIFT +: DATA_W];
      rs      = neg6_ff ? ONE_Q16 - RES_W'(q_ff) : ONE_Q16 + RES_W'(q_ff);
      if (rs > SAT_HI) begin
         value = SAT_HI[DATA_W-1:0];
      end else if (rs < SAT_LO) begin
         value = SAT_LO[DATA_W-1:0];
      end else begin
         value = rs[DATA_W-1:0];
      end
      res.valid = c6_ff.valid;
      res.last  = c6_ff.last;
      res.value = value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c2_ff <= '0;
         c3_ff <= '0;
         c4_ff <= '0;
         c5_ff <= '0;
         c6_ff <= '0;
      end else if (move) begin
         c2_ff <= c2_in;
         c3_ff <= c2_ff;
         c4_ff <= c3_ff;
         c5_ff <= c4_ff;
         c6_ff <= c5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         psa_ff  <= psa_in;
         psb_ff  <= psb_in;
         sum_ff  <= sum_in;
         neg4_ff <= neg4_in;
         half_ff <= half_in;
         neg5_ff <= neg4_ff;
         plo_ff  <= plo_in;
         phi_ff  <= phi_in;
         neg6_ff <= neg5_ff;
         q_ff    <= q_in;
      end
   end

endmodule
